### src/c1ks_pkg.sv
// Shared types, constants and functions for the Crypto1 keystream generator.
// Used by c1ks_datapath and crypto1_keystream_generator; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package c1ks_pkg;

  // Register widths.
  localparam int unsigned HalfW = 24;
  localparam int unsigned KeyW  = 48;
  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 5;

  // Request type codes.
  typedef enum logic [1:0] {
    REQ_LOAD = 2'd0,
    REQ_BIT  = 2'd1,
    REQ_BYTE = 2'd2,
    REQ_WORD = 2'd3
  } req_e;

  // Configuration register indexes.
  localparam logic [1:0] CFG_KEY       = 2'd0;
  localparam logic [1:0] CFG_TAPS_ODD  = 2'd1;
  localparam logic [1:0] CFG_TAPS_EVEN = 2'd2;

  // Reset values of the tap masks.
  localparam logic [HalfW-1:0] TAPS_ODD_RST  = 24'h29CE5C;
  localparam logic [HalfW-1:0] TAPS_EVEN_RST = 24'h870804;

  // Filter tables: five 4-input functions and a 5-input combiner.
  localparam logic [19:0] FLT_A   = 20'hf22c0;
  localparam logic [19:0] FLT_B   = 20'h6c9c0;
  localparam logic [19:0] FLT_C   = 20'h3c8b0;
  localparam logic [19:0] FLT_D   = 20'h1e458;
  localparam logic [19:0] FLT_E   = 20'h0d938;
  localparam logic [31:0] FLT_OUT = 32'hEC57E80A;
  localparam logic [15:0] PAR_TBL = 16'h6996;

  // Microprogram addresses (sequencer state).
  localparam logic [1:0] UPC_IDLE = 2'd0;
  localparam logic [1:0] UPC_LOAD = 2'd1;
  localparam logic [1:0] UPC_STEP = 2'd2;
  localparam logic [1:0] UPC_DONE = 2'd3;

  // Branch conditions of a control word.
  typedef enum logic [1:0] {
    COND_ALWAYS   = 2'd0,
    COND_DISPATCH = 2'd1,
    COND_COUNT    = 2'd2,
    COND_OUT      = 2'd3
  } cond_e;

  // One control word of the microprogram.
  typedef struct packed {
    logic       load;
    logic       step;
    logic       emit;
    cond_e      cond;
    logic [1:0] next;
  } uop_t;

  // Control group from the sequencer to the datapath.
  typedef struct packed {
    logic            clear;
    logic            load;
    logic            step;
    logic [PosW-1:0] pos;
  } dp_ctrl_t;

  // Microprogram ROM.
  function automatic uop_t uop_rom(input logic [1:0] upc);
    uop_t u;
    u = '{load: 1'b0, step: 1'b0, emit: 1'b0, cond: COND_ALWAYS, next: UPC_IDLE};
    case (upc)
      UPC_IDLE: u = '{load: 1'b0, step: 1'b0, emit: 1'b0, cond: COND_DISPATCH,
                      next: UPC_STEP};
      UPC_LOAD: u = '{load: 1'b1, step: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
                      next: UPC_DONE};
      UPC_STEP: u = '{load: 1'b0, step: 1'b1, emit: 1'b0, cond: COND_COUNT,
                      next: UPC_DONE};
      UPC_DONE: u = '{load: 1'b0, step: 1'b0, emit: 1'b1, cond: COND_OUT,
                      next: UPC_IDLE};
      default:  u = '{load: 1'b0, step: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
                      next: UPC_IDLE};
    endcase
    return u;
  endfunction

  // Nonlinear 20-input filter of the odd half.
  function automatic logic filter20(input logic [HalfW-1:0] x);
    logic [4:0] f;
    f[4] = FLT_A[5'({1'b0, x[3:0]} + 5'd4)];
    f[3] = FLT_B[5'({1'b0, x[7:4]} + 5'd3)];
    f[2] = FLT_C[5'({1'b0, x[11:8]} + 5'd2)];
    f[1] = FLT_D[5'({1'b0, x[15:12]} + 5'd1)];
    f[0] = FLT_E[{1'b0, x[19:16]}];
    return FLT_OUT[f];
  endfunction

  // Parity of a 24-bit word, folded down to a nibble lookup.
  function automatic logic parity24(input logic [HalfW-1:0] x);
    logic [11:0] a;
    logic [5:0]  b;
    logic [3:0]  c;
    a = x[23:12] ^ x[11:0];
    b = a[11:6] ^ a[5:0];
    c = b[3:0] ^ {2'b00, b[5:4]};
    return PAR_TBL[c];
  endfunction

endpackage

`default_nettype wire

### src/c1ks_datapath.sv
// Cipher register halves, filter, feedback and keystream collection.
// Depends on c1ks_pkg; driven by the sequencer in crypto1_keystream_generator.
`timescale 1ns / 1ps
`default_nettype none

module c1ks_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire c1ks_pkg::dp_ctrl_t             ctrl_i,
  input  wire logic [c1ks_pkg::KeyW-1:0]      key_i,
  input  wire logic [c1ks_pkg::HalfW-1:0]     taps_odd_i,
  input  wire logic [c1ks_pkg::HalfW-1:0]     taps_even_i,
  input  wire logic [c1ks_pkg::DataW-1:0]     data_i,
  input  wire logic                           enc_i,
  output logic [c1ks_pkg::DataW-1:0]          keystream_o
);

  logic [c1ks_pkg::HalfW-1:0] odd_q, odd_d;
  logic [c1ks_pkg::HalfW-1:0] even_q, even_d;
  logic [c1ks_pkg::HalfW-1:0] odd_ld, even_ld;
  logic [c1ks_pkg::DataW-1:0] acc_q, acc_d;
  logic                       flt_out;
  logic                       fb_bit;

  // Key bits land in the halves in the interleaved order, bit-reversed within each byte.
  always_comb begin
    for (int k = 0; k < 24; k++) begin
      odd_ld[23-k]  = key_i[6'((46 - 2 * k) ^ 7)];
      even_ld[23-k] = key_i[6'((47 - 2 * k) ^ 7)];
    end
  end

  // One cipher bit: filter the odd half, form feedback, shift and swap.
  assign flt_out = c1ks_pkg::filter20(odd_q);
  assign fb_bit  = (flt_out & enc_i) ^ data_i[ctrl_i.pos]
                 ^ c1ks_pkg::parity24((odd_q & taps_odd_i) ^ (even_q & taps_even_i));

  always_comb begin
    odd_d  = odd_q;
    even_d = even_q;
    acc_d  = acc_q;
    if (ctrl_i.clear) begin
      acc_d = '0;
    end
    if (ctrl_i.load) begin
      odd_d  = odd_ld;
      even_d = even_ld;
    end else if (ctrl_i.step) begin
      odd_d              = {even_q[c1ks_pkg::HalfW-2:0], fb_bit};
      even_d             = odd_q;
      acc_d[ctrl_i.pos]  = flt_out;
    end
  end

  // Cipher state is control state and is cleared by reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      odd_q  <= '0;
      even_q <= '0;
    end else begin
      odd_q  <= odd_d;
      even_q <= even_d;
    end
  end

  // Keystream collector needs no reset.
  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign keystream_o = acc_q;

endmodule

`default_nettype wire

### src/crypto1_keystream_generator.sv
// Top level: handshakes, configuration registers and the microcoded sequencer.
// Depends on c1ks_pkg and c1ks_datapath.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | input     | in_valid_i / in_stall_o  | req_type_i, data_in_i, encrypted_feedback_i
//   out     | output    | out_valid_o / out_stall_i| keystream_o
//   cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
// A request occupies the block for the idle step that takes the transfer, the datapath
// steps (a key load, or one cipher step per bit of a bit, byte or word, one cipher bit per
// cycle), and a final step that loads the output register. The input is stalled until the
// sequencer is back in idle. Reset clears the cipher halves and the key and sets the tap
// masks to their defaults. A held result stalls the sequencer at its final step only, until
// the output register frees up.
`timescale 1ns / 1ps
`default_nettype none

module crypto1_keystream_generator (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [1:0]                 req_type_i,
  input  wire logic [c1ks_pkg::DataW-1:0] data_in_i,
  input  wire logic                       encrypted_feedback_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic [c1ks_pkg::DataW-1:0]      keystream_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [c1ks_pkg::KeyW-1:0]  cfg_wdata_i
);

  logic [c1ks_pkg::KeyW-1:0]  key_q;
  logic [c1ks_pkg::HalfW-1:0] taps_odd_q;
  logic [c1ks_pkg::HalfW-1:0] taps_even_q;

  logic [1:0]                 upc_q, upc_d;
  logic [c1ks_pkg::PosW-1:0]  cnt_q, cnt_d;
  logic [c1ks_pkg::PosW-1:0]  cnt_last;
  logic [1:0]                 type_q;
  logic [c1ks_pkg::DataW-1:0] data_q;
  logic                       enc_q;

  logic                       out_valid_q;
  logic [c1ks_pkg::DataW-1:0] keystream_q;
  logic [c1ks_pkg::DataW-1:0] dp_keystream;

  c1ks_pkg::uop_t             uop;
  c1ks_pkg::dp_ctrl_t         dp_ctrl;
  logic                       in_xfer;
  logic                       out_free;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q       <= '0;
      taps_odd_q  <= c1ks_pkg::TAPS_ODD_RST;
      taps_even_q <= c1ks_pkg::TAPS_EVEN_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        c1ks_pkg::CFG_KEY:       key_q       <= cfg_wdata_i;
        c1ks_pkg::CFG_TAPS_ODD:  taps_odd_q  <= cfg_wdata_i[c1ks_pkg::HalfW-1:0];
        c1ks_pkg::CFG_TAPS_EVEN: taps_even_q <= cfg_wdata_i[c1ks_pkg::HalfW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake terms.
  assign in_stall_o = (upc_q != c1ks_pkg::UPC_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  // Last bit count of the current request.
  always_comb begin
    case (type_q)
      c1ks_pkg::REQ_WORD: cnt_last = 5'd31;
      c1ks_pkg::REQ_BYTE: cnt_last = 5'd7;
      default:            cnt_last = 5'd0;
    endcase
  end

  // Fetch the control word and pick the next microprogram address.
  assign uop = c1ks_pkg::uop_rom(upc_q);

  always_comb begin
    upc_d = upc_q;
    case (uop.cond)
      c1ks_pkg::COND_ALWAYS: upc_d = uop.next;
      c1ks_pkg::COND_DISPATCH: begin
        if (in_xfer) begin
          upc_d = (req_type_i == c1ks_pkg::REQ_LOAD) ? c1ks_pkg::UPC_LOAD : uop.next;
        end
      end
      c1ks_pkg::COND_COUNT: begin
        if (cnt_q == cnt_last) upc_d = uop.next;
      end
      c1ks_pkg::COND_OUT: begin
        if (out_free) upc_d = uop.next;
      end
      default: upc_d = c1ks_pkg::UPC_IDLE;
    endcase
  end

  // Bit counter runs over the cipher steps of one request.
  always_comb begin
    cnt_d = cnt_q;
    if (in_xfer) begin
      cnt_d = '0;
    end else if (uop.step) begin
      cnt_d = cnt_q + 5'd1;
    end
  end

  // Words go most significant byte first, bits within a byte LSB first.
  always_comb begin
    dp_ctrl.clear = in_xfer;
    dp_ctrl.load  = uop.load;
    dp_ctrl.step  = uop.step;
    if (type_q == c1ks_pkg::REQ_WORD) begin
      dp_ctrl.pos = {~cnt_q[4:3], cnt_q[2:0]};
    end else begin
      dp_ctrl.pos = {2'b00, cnt_q[2:0]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= c1ks_pkg::UPC_IDLE;
      cnt_q <= '0;
    end else begin
      upc_q <= upc_d;
      cnt_q <= cnt_d;
    end
  end

  // Request capture on an input transfer.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      type_q <= req_type_i;
      data_q <= data_in_i;
      enc_q  <= encrypted_feedback_i;
    end
  end

  c1ks_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (dp_ctrl),
    .key_i       (key_q),
    .taps_odd_i  (taps_odd_q),
    .taps_even_i (taps_even_q),
    .data_i      (data_q),
    .enc_i       (enc_q),
    .keystream_o (dp_keystream)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (uop.emit && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (uop.emit && out_free) begin
      keystream_q <= dp_keystream;
    end
  end

  assign out_valid_o = out_valid_q;
  assign keystream_o = keystream_q;

  // An accepted request always leaves the idle step.
  a_xfer_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (upc_q != c1ks_pkg::UPC_IDLE))
    else $error("sequencer stayed idle after an input transfer");

  // A key load step is always followed by the final step.
  a_load_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == c1ks_pkg::UPC_LOAD) |=> (upc_q == c1ks_pkg::UPC_DONE))
    else $error("key load did not finish in one cycle");

  // The bit counter never runs past the request length.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (upc_q == c1ks_pkg::UPC_STEP) |-> (cnt_q <= cnt_last))
    else $error("bit counter overran the request length");

  // A new result only appears out of the final step.
  a_out_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(upc_q == c1ks_pkg::UPC_DONE))
    else $error("result raised outside the final step");

endmodule

`default_nettype wire

### sim/crypto1_keystream_generator_tb.sv
// Self-checking testbench for crypto1_keystream_generator: key loads and bit, byte
// and word cipher steps under random idling, checked against an in-bench cipher model.
// Depends on c1ks_pkg and the RTL of the block.
`timescale 1ns / 1ps

module crypto1_keystream_generator_tb;

  localparam int unsigned IdleLimit   = 4000;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned PhaseItems  = 228;
  localparam int unsigned NumPhases   = 8;
  localparam int unsigned MaxReported = 10;

  // Cipher model and the queue of keystream words still owed by the block.
  class keystream_scoreboard;
    logic [c1ks_pkg::KeyW-1:0]  key_reg   = '0;
    logic [c1ks_pkg::HalfW-1:0] taps_odd  = c1ks_pkg::TAPS_ODD_RST;
    logic [c1ks_pkg::HalfW-1:0] taps_even = c1ks_pkg::TAPS_EVEN_RST;
    logic [c1ks_pkg::HalfW-1:0] half_odd  = '0;
    logic [c1ks_pkg::HalfW-1:0] half_even = '0;
    logic [c1ks_pkg::DataW-1:0] owed_ks[$];
    int unsigned                mismatches = 0;
    int unsigned                checked    = 0;

    function void write_reg(logic [1:0] idx, logic [c1ks_pkg::KeyW-1:0] value);
      case (idx)
        c1ks_pkg::CFG_KEY:       key_reg   = value;
        c1ks_pkg::CFG_TAPS_ODD:  taps_odd  = value[c1ks_pkg::HalfW-1:0];
        c1ks_pkg::CFG_TAPS_EVEN: taps_even = value[c1ks_pkg::HalfW-1:0];
        default: ;
      endcase
    endfunction

    // Five 4-input lookups pick one bit of the 5-input combiner table.
    function logic filter_out(logic [c1ks_pkg::HalfW-1:0] x);
      logic [4:0]  sel;
      logic [19:0] sh;
      sh = c1ks_pkg::FLT_A >> x[3:0];
      sel[4] = sh[4];
      sh = c1ks_pkg::FLT_B >> x[7:4];
      sel[3] = sh[3];
      sh = c1ks_pkg::FLT_C >> x[11:8];
      sel[2] = sh[2];
      sh = c1ks_pkg::FLT_D >> x[15:12];
      sel[1] = sh[1];
      sh = c1ks_pkg::FLT_E >> x[19:16];
      sel[0] = sh[0];
      return c1ks_pkg::FLT_OUT[sel];
    endfunction

    // One cipher clock: output the filter bit, shift feedback into even, swap halves.
    function logic cipher_bit(logic din, logic enc);
      logic                       ks;
      logic                       fb;
      logic [c1ks_pkg::HalfW-1:0] shifted;
      ks = filter_out(half_odd);
      fb = (ks & enc) ^ din ^ (^(half_odd & taps_odd)) ^ (^(half_even & taps_even));
      shifted = {half_even[c1ks_pkg::HalfW-2:0], fb};
      half_even = half_odd;
      half_odd = shifted;
      return ks;
    endfunction

    function logic [7:0] cipher_byte(logic [7:0] din, logic enc);
      logic [7:0] r;
      for (int i = 0; i < 8; i++) r[i] = cipher_bit(din[i], enc);
      return r;
    endfunction

    // Interleaved key bits, bit-reversed inside each 8-bit group.
    function void load_key();
      half_odd = '0;
      half_even = '0;
      for (int k = 0; k < 24; k++) begin
        half_odd = {half_odd[c1ks_pkg::HalfW-2:0], key_reg[(46 - 2 * k) ^ 7]};
        half_even = {half_even[c1ks_pkg::HalfW-2:0], key_reg[(47 - 2 * k) ^ 7]};
      end
    endfunction

    function void note_request(c1ks_pkg::req_e kind, logic [c1ks_pkg::DataW-1:0] data,
                               logic enc);
      logic [c1ks_pkg::DataW-1:0] ks;
      ks = '0;
      case (kind)
        c1ks_pkg::REQ_LOAD: load_key();
        c1ks_pkg::REQ_BIT:  ks[0] = cipher_bit(data[0], enc);
        c1ks_pkg::REQ_BYTE: ks[7:0] = cipher_byte(data[7:0], enc);
        default: begin
          for (int j = 0; j < 4; j++) ks = {ks[23:0], cipher_byte(data[31 - 8 * j -: 8], enc)};
        end
      endcase
      owed_ks.push_back(ks);
    endfunction

    function void check_keystream(logic [c1ks_pkg::DataW-1:0] actual);
      logic [c1ks_pkg::DataW-1:0] want;
      checked++;
      if (owed_ks.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("Unexpected keystream result %08h with nothing outstanding", actual);
        return;
      end
      want = owed_ks.pop_front();
      if (actual !== want) begin
        mismatches++;
        if (mismatches <= MaxReported)
          $display("Keystream mismatch %0d: expected %08h, got %08h", mismatches, want, actual);
      end
    endfunction
  endclass

  logic                       clk_i                = 1'b0;
  logic                       rst_ni               = 1'b0;
  logic                       in_valid_i           = 1'b0;
  logic                       in_stall_o;
  logic [1:0]                 req_type_i           = c1ks_pkg::REQ_LOAD;
  logic [c1ks_pkg::DataW-1:0] data_in_i            = '0;
  logic                       encrypted_feedback_i = 1'b0;
  logic                       out_valid_o;
  logic                       out_stall_i          = 1'b0;
  logic [c1ks_pkg::DataW-1:0] keystream_o;
  logic                       cfg_we_i             = 1'b0;
  logic [1:0]                 cfg_index_i          = c1ks_pkg::CFG_KEY;
  logic [c1ks_pkg::KeyW-1:0]  cfg_wdata_i          = '0;

  keystream_scoreboard sb = new;

  int unsigned stall_pct   = 0;
  int unsigned gap_mode    = 0;
  bit          hold_req    = 1'b0;
  int unsigned idle_cycles = 0;
  int unsigned req_count[4];
  int unsigned settings    = 0;

  always #4 clk_i = ~clk_i;

  crypto1_keystream_generator dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_stall_o           (in_stall_o),
    .req_type_i           (req_type_i),
    .data_in_i            (data_in_i),
    .encrypted_feedback_i (encrypted_feedback_i),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .keystream_o          (keystream_o),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_wdata_i          (cfg_wdata_i)
  );

  // Result side: check each output transfer, then choose the next stall value.
  always @(posedge clk_i) begin : result_side
    int unsigned hold_left;
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_keystream(keystream_o);
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pct > 0 && $urandom_range(0, 199) == 0) begin
      hold_left = $urandom_range(20, 60);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Watchdog on cycles without any transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transfer for %0d cycles", IdleLimit);
        $display("FAIL crypto1_keystream_generator");
        $finish;
      end
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    case (gap_mode)
      0: return 0;
      1: return (r < 70) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      default: return (r < 40) ? 0 : (r < 90) ? $urandom_range(1, 6) : $urandom_range(20, 60);
    endcase
  endfunction

  // Offer one request, wait for its transfer, then idle for a random gap.
  task automatic send_request(c1ks_pkg::req_e kind, logic [c1ks_pkg::DataW-1:0] data,
                              logic enc);
    int unsigned gap;
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    data_in_i <= data;
    encrypted_feedback_i <= enc;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(kind, data, enc);
    req_count[kind]++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_random();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) send_request(c1ks_pkg::REQ_LOAD, $urandom, 1'($urandom_range(0, 1)));
    else if (r < 28) send_request(c1ks_pkg::REQ_BIT, $urandom, 1'($urandom_range(0, 1)));
    else if (r < 58) send_request(c1ks_pkg::REQ_BYTE, $urandom, 1'($urandom_range(0, 1)));
    else send_request(c1ks_pkg::REQ_WORD, $urandom, 1'($urandom_range(0, 1)));
  endtask

  // Stop offering and let every owed result arrive before touching the registers.
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.owed_ks.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_config(logic [c1ks_pkg::KeyW-1:0] key, logic [c1ks_pkg::KeyW-1:0] todd,
                              logic [c1ks_pkg::KeyW-1:0] teven);
    cfg_we_i <= 1'b1;
    cfg_index_i <= c1ks_pkg::CFG_KEY;
    cfg_wdata_i <= key;
    @(posedge clk_i);
    sb.write_reg(c1ks_pkg::CFG_KEY, key);
    cfg_index_i <= c1ks_pkg::CFG_TAPS_ODD;
    cfg_wdata_i <= todd;
    @(posedge clk_i);
    sb.write_reg(c1ks_pkg::CFG_TAPS_ODD, todd);
    cfg_index_i <= c1ks_pkg::CFG_TAPS_EVEN;
    cfg_wdata_i <= teven;
    @(posedge clk_i);
    sb.write_reg(c1ks_pkg::CFG_TAPS_EVEN, teven);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    settings++;
  endtask

  initial begin
    logic [c1ks_pkg::KeyW-1:0] rnd_key;
    logic [c1ks_pkg::KeyW-1:0] rnd_odd;
    logic [c1ks_pkg::KeyW-1:0] rnd_even;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: steps from the all-zero register under reset settings.
    gap_mode = 1;
    stall_pct = 25;
    send_request(c1ks_pkg::REQ_BIT, 32'h0000_0000, 1'b0);
    send_request(c1ks_pkg::REQ_BYTE, 32'h0000_00FF, 1'b1);
    send_request(c1ks_pkg::REQ_WORD, 32'hFFFF_FFFF, 1'b0);
    send_request(c1ks_pkg::REQ_LOAD, 32'hDEAD_BEEF, 1'b1);
    send_request(c1ks_pkg::REQ_WORD, 32'h0000_0001, 1'b1);
    drain();

    // Directed: all-ones key, with the reset taps written back explicitly.
    write_config(48'hFFFF_FFFF_FFFF, {24'hFFFFFF, c1ks_pkg::TAPS_ODD_RST},
                 {24'h0, c1ks_pkg::TAPS_EVEN_RST});
    send_request(c1ks_pkg::REQ_LOAD, 32'hFFFF_FFFF, 1'b1);
    send_request(c1ks_pkg::REQ_BIT, 32'h0000_0001, 1'b0);
    send_request(c1ks_pkg::REQ_BIT, 32'hFFFF_FFFE, 1'b1);
    send_request(c1ks_pkg::REQ_BIT, 32'h0000_0001, 1'b1);
    send_request(c1ks_pkg::REQ_BYTE, 32'hFFFF_FF00, 1'b0);
    send_request(c1ks_pkg::REQ_BYTE, 32'h0000_00A5, 1'b1);
    send_request(c1ks_pkg::REQ_WORD, 32'h0000_0000, 1'b1);
    send_request(c1ks_pkg::REQ_WORD, 32'h8000_0001, 1'b0);
    send_request(c1ks_pkg::REQ_WORD, 32'hFFFF_FFFF, 1'b1);
    send_request(c1ks_pkg::REQ_LOAD, 32'h0000_0000, 1'b0);
    send_request(c1ks_pkg::REQ_WORD, 32'h1234_5678, 1'b1);
    drain();

    // Directed: a key that is not symmetric under the bit interleave, then zero taps.
    write_config(48'h0123_4567_89AB, 48'h0, 48'h0);
    send_request(c1ks_pkg::REQ_LOAD, 32'h0, 1'b0);
    send_request(c1ks_pkg::REQ_WORD, 32'hA5A5_5A5A, 1'b0);
    send_request(c1ks_pkg::REQ_BYTE, 32'h0000_003C, 1'b1);
    send_request(c1ks_pkg::REQ_WORD, 32'hFFFF_FFFF, 1'b1);
    drain();

    // Random phases, each under its own register setting and idling profile.
    for (int p = 0; p < NumPhases; p++) begin
      rnd_key = 48'({$urandom, $urandom});
      rnd_odd = 48'({$urandom, $urandom});
      rnd_even = 48'({$urandom, $urandom});
      case (p)
        0: write_config(rnd_key, 48'(c1ks_pkg::TAPS_ODD_RST), 48'(c1ks_pkg::TAPS_EVEN_RST));
        1: write_config(rnd_key, rnd_odd, rnd_even);
        2: write_config(48'hFFFF_FFFF_FFFF, 48'hFF_FFFF, 48'hFF_FFFF);
        3: write_config(48'h0, 48'h0, 48'h0);
        4: write_config(rnd_key, 48'hFF_FFFF, 48'h0);
        5: write_config(rnd_key, 48'h0, rnd_even);
        6: write_config(rnd_key, rnd_odd, 48'hFF_FFFF);
        default: write_config(rnd_key, 48'(c1ks_pkg::TAPS_ODD_RST),
                              48'(c1ks_pkg::TAPS_EVEN_RST));
      endcase
      gap_mode = (p == 0 || p == 1) ? 0 : (p % 3 == 2) ? 2 : 1;
      stall_pct = (p == 0) ? 0 : (p == 2 || p == 6) ? 60 : 25;
      // Every phase starts from a fresh key load so the register holds key material.
      send_request(c1ks_pkg::REQ_LOAD, $urandom, 1'($urandom_range(0, 1)));
      if (p == 1) hold_req = 1'b1;
      for (int i = 1; i < PhaseItems; i++) send_random();
      drain();
    end

    repeat (40) @(posedge clk_i);
    $display("Ran %0d loads and %0d bit, %0d byte, %0d word steps under %0d register settings.",
             req_count[c1ks_pkg::REQ_LOAD], req_count[c1ks_pkg::REQ_BIT],
             req_count[c1ks_pkg::REQ_BYTE], req_count[c1ks_pkg::REQ_WORD], settings);
    $display("Checked %0d keystream results, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed_ks.size() == 0) begin
      $display("PASS crypto1_keystream_generator");
    end else begin
      $display("FAIL crypto1_keystream_generator");
    end
    $finish;
  end

endmodule

### filelist.f
src/c1ks_pkg.sv
src/c1ks_datapath.sv
src/crypto1_keystream_generator.sv
sim/crypto1_keystream_generator_tb.sv
